// ----- rtl/core/swap_slot_bitmap_allocator_macros.svh -----
// assertion macros for the swap slot bitmap allocator
`ifndef SWAP_SLOT_BITMAP_ALLOCATOR_MACROS_SVH
`define SWAP_SLOT_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define SSBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SSBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ssba_pkg.sv -----
// shared types and constants for the swap slot bitmap allocator
package ssba_pkg;

    localparam int SLOTS_DEF            = 1024;
    localparam int SECTORS_PER_SLOT_DEF = 8;
    localparam int WORD_W               = 32;
    localparam int COUNT_W              = 11;
    localparam int KIND_W               = 2;
    localparam int SLOT_W               = 10;
    localparam int SECTOR_W             = 13;
    localparam int STATUS_W             = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_SWAPIN = 2'd1,
        KIND_FREE   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_UNUSED = 2'd2,
        STAT_RANGE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WAIT,
        S_SCAN,
        S_CHECK,
        S_EMIT
    } state_t;

endpackage

// ----- rtl/core/swap_slot_bitmap_allocator.sv -----
// swap slot bitmap allocator: first-fit free map with per-sector result bursts
// allocate scans map rows (32 slots a row) until a free slot is found, then emits a sector burst
// swap in checks its slot's row, then emits a sector burst; free, slot errors and map full give a single result
// the map row read and single compare/priority unit, reused row by row, sets the scan time
// reset: map rows are rewritten to all free, one row a cycle, busy meanwhile
// results come one per cycle with no backpressure; slot count resets to 1024
`include "swap_slot_bitmap_allocator_macros.svh"

module swap_slot_bitmap_allocator
    import ssba_pkg::*;
#(
    parameter int SLOTS            = SLOTS_DEF,
    parameter int SECTORS_PER_SLOT = SECTORS_PER_SLOT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // request transfer
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic [SLOT_W-1:0]   slot,
    // slot count register
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_data,
    // result transfer
    output logic                valid,
    output logic [SLOT_W-1:0]   slot_index,
    output logic [SECTOR_W-1:0] sector,
    output logic [STATUS_W-1:0] status,
    output logic                last
);

    localparam int BIT_W  = $clog2(WORD_W);
    localparam int ROWS   = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IX_W   = ROW_W + BIT_W;
    localparam int CW_A   = (COUNT_W > $clog2(SLOTS + 1)) ? COUNT_W : $clog2(SLOTS + 1);
    localparam int CW     = (CW_A > IX_W + 1) ? CW_A : IX_W + 1;
    localparam int OFF_W  = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(SECTORS_PER_SLOT - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    // control state
    state_t               state_reg,  state_next;
    kind_t                kind_reg,   kind_next;
    logic [ROW_W-1:0]     row_reg,    row_next;
    logic [BIT_W-1:0]     bit_reg,    bit_next;
    logic [COUNT_W-1:0]   count_reg;

    // work registers
    logic [SLOT_W-1:0]    slot_reg,   slot_next;
    logic [IX_W-1:0]      ix_reg,     ix_next;
    logic [SECTOR_W-1:0]  sec_reg,    sec_next;
    logic [OFF_W-1:0]     off_reg,    off_next;

    // result registers
    logic                 valid_reg,  valid_next;
    logic [SLOT_W-1:0]    sidx_reg,   sidx_next;
    logic [SECTOR_W-1:0]  sector_reg, sector_next;
    status_t              status_reg, status_next;
    logic                 last_reg,   last_next;

    // free map, one row of WORD_W slots per entry, 1 means free
    logic [WORD_W-1:0]    map_mem [ROWS];
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 mem_we;
    logic [WORD_W-1:0]    mem_wdata;

    // shared row evaluation
    logic [CW-1:0]        act_count;
    logic [CW-1:0]        row_end;
    logic [WORD_W-1:0]    row_mask;
    logic [WORD_W-1:0]    masked;
    logic [WORD_W-1:0]    lowest;
    logic [BIT_W-1:0]     low_bit;
    logic [IX_W-1:0]      found_ix;
    logic [IX_W-1:0]      chk_ix;
    logic [IX_W-1:0]      req_ix;

    assign busy       = (state_reg != S_IDLE);
    assign valid      = valid_reg;
    assign slot_index = sidx_reg;
    assign sector     = sector_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    // active count is the register clamped to the map size
    assign act_count = (CW'(count_reg) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(count_reg);

    // slot one past the row being looked at
    assign row_end = (CW'(row_reg) + CW'(1)) << BIT_W;

    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
        begin
            row_mask[b] = (CW'({row_reg, BIT_W'(b)}) < act_count);
        end
    end

    assign masked = rd_data_reg & row_mask;
    assign lowest = masked & (~masked + WORD_W'(1));

    // encode the isolated lowest free bit
    always_comb
    begin
        low_bit = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            if (lowest[b])
            begin
                low_bit = low_bit | BIT_W'(b);
            end
        end
    end

    assign found_ix = {row_reg, low_bit};
    assign chk_ix   = {row_reg, bit_reg};
    assign req_ix   = IX_W'(slot);

    // slot count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_data;
        end
    end

    // map memory, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[row_reg] <= mem_wdata;
        end
        rd_data_reg <= map_mem[row_reg];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            kind_reg  <= KIND_ALLOC;
            row_reg   <= '0;
            bit_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            row_reg   <= row_next;
            bit_reg   <= bit_next;
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        ix_reg     <= ix_next;
        sec_reg    <= sec_next;
        off_reg    <= off_next;
        sidx_reg   <= sidx_next;
        sector_reg <= sector_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        row_next    = row_reg;
        bit_next    = bit_reg;
        slot_next   = slot_reg;
        ix_next     = ix_reg;
        sec_next    = sec_reg;
        off_next    = off_reg;
        valid_next  = 1'b0;
        sidx_next   = sidx_reg;
        sector_next = sector_reg;
        status_next = status_reg;
        last_next   = last_reg;
        mem_we      = 1'b0;
        mem_wdata   = rd_data_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // mark one row all free per cycle
                mem_we    = 1'b1;
                mem_wdata = '1;
                if (row_reg == ROW_LAST)
                begin
                    row_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    slot_next = slot;
                    case (kind)
                        KIND_ALLOC:
                        begin
                            kind_next  = KIND_ALLOC;
                            row_next   = '0;
                            state_next = S_WAIT;
                        end
                        KIND_SWAPIN, KIND_FREE:
                        begin
                            kind_next = (kind == KIND_SWAPIN) ? KIND_SWAPIN : KIND_FREE;
                            if (CW'(slot) >= act_count)
                            begin
                                // slot beyond active count, map untouched
                                valid_next  = 1'b1;
                                sidx_next   = slot;
                                sector_next = '0;
                                status_next = STAT_RANGE;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                row_next   = req_ix[IX_W-1:BIT_W];
                                bit_next   = req_ix[BIT_W-1:0];
                                state_next = S_WAIT;
                            end
                        end
                        default:
                        begin
                            // unused kind, no result
                        end
                    endcase
                end
            end

            S_WAIT:
            begin
                // row read in flight
                state_next = (kind_reg == KIND_ALLOC) ? S_SCAN : S_CHECK;
            end

            S_SCAN:
            begin
                if (|masked)
                begin
                    // take the lowest free slot in this row
                    mem_we     = 1'b1;
                    mem_wdata  = rd_data_reg & ~lowest;
                    ix_next    = found_ix;
                    sec_next   = SECTOR_W'(found_ix * SECTORS_PER_SLOT);
                    off_next   = '0;
                    state_next = S_EMIT;
                end
                else if (row_end >= act_count)
                begin
                    // no free slot below the active count
                    valid_next  = 1'b1;
                    sidx_next   = '0;
                    sector_next = '0;
                    status_next = STAT_FULL;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    row_next   = row_reg + ROW_W'(1);
                    state_next = S_WAIT;
                end
            end

            S_CHECK:
            begin
                if (rd_data_reg[bit_reg])
                begin
                    // slot is free, nothing to release
                    valid_next  = 1'b1;
                    sidx_next   = slot_reg;
                    sector_next = '0;
                    status_next = STAT_UNUSED;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg | (WORD_W'(1) << bit_reg);
                    if (kind_reg == KIND_SWAPIN)
                    begin
                        ix_next    = chk_ix;
                        sec_next   = SECTOR_W'(chk_ix * SECTORS_PER_SLOT);
                        off_next   = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        valid_next  = 1'b1;
                        sidx_next   = slot_reg;
                        sector_next = '0;
                        status_next = STAT_OK;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_EMIT:
            begin
                // one sector result per cycle
                valid_next  = 1'b1;
                sidx_next   = SLOT_W'(ix_reg);
                sector_next = sec_reg;
                status_next = STAT_OK;
                last_next   = (off_reg == OFF_LAST);
                sec_next    = sec_reg + SECTOR_W'(1);
                off_next    = off_reg + OFF_W'(1);
                if (off_reg == OFF_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a sector burst runs without gaps
    `SSBA_ASSERT_NEXT(a_burst_contig, valid && !last, valid, "sector burst broken")
    // burst sectors count up by one
    `SSBA_ASSERT_NEXT(a_burst_step, valid && !last,
        sector == SECTOR_W'($past(sector) + SECTOR_W'(1)), "sector step wrong")
    // the block stays busy inside a burst
    `SSBA_ASSERT_NOW(a_burst_busy, valid && !last, busy, "idle during burst")
    // error results are single transfers
    `SSBA_ASSERT_NOW(a_err_last, valid && (status != STAT_OK), last, "error not last")

endmodule
